FILE: hdl/rslb_pkg.sv
// Shared types and constants of the sprite line blitter.
package rslb_pkg;

    // Input command codes
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_STREAM = 1'b1;

    // Stream tokens, bits 31:24 of a token word
    localparam logic [7:0] TOK_END  = 8'd0;
    localparam logic [7:0] TOK_LINE = 8'd1;
    localparam logic [7:0] TOK_DRAW = 8'd2;
    localparam logic [7:0] TOK_SKIP = 8'd3;

    // Result kinds
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_COLOR   = 3'd4;

    // Reset values of the configuration registers
    localparam logic [13:0] ROW_BYTES_RST    = 14'd640;
    localparam logic [11:0] SCREEN_WIDTH_RST = 12'd640;
    localparam logic [11:0] VISIBLE_ROWS_RST = 12'd480;

    // Command queue between front and back; depth is a power of two
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic [23:0] frame_base;
        logic [13:0] row_bytes;
        logic [11:0] screen_width;
        logic [11:0] visible_rows;
        logic        high_color;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_START,
        OP_PIXELS,
        OP_SKIP,
        OP_FINISH
    } t_op;

    // One classified request for the back end
    typedef struct packed {
        t_op         op;
        logic [31:0] data;   // pixel word, start x or skip count
        logic [15:0] y;
        logic [23:0] zoom;
        logic [2:0]  take;   // pixels in this word, 1 to 4
        logic        eos;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_OFFSET,
        BK_SKIP
    } t_back_state;

endpackage

FILE: hdl/rslb_if.sv
// Handshake channel interfaces: input stream, result stream, configuration writes.
interface rslb_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] stream_word;
    logic signed [31:0] start_x;
    logic signed [15:0] start_y;
    logic [23:0] zoom;

    modport source (output valid, cmd, stream_word, start_x, start_y, zoom, input ready);
    modport sink   (input valid, cmd, stream_word, start_x, start_y, zoom, output ready);
endinterface

interface rslb_out_if #(parameter int ADDR_BITS = 24);
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [ADDR_BITS-1:0] address;
    logic [15:0]          pixel;
    logic                 end_of_shape;
    logic                 last;

    modport source (output valid, kind, address, pixel, end_of_shape, last, input ready);
    modport sink   (input valid, kind, address, pixel, end_of_shape, last, output ready);
endinterface

interface rslb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/rle_sprite_line_blitter.sv
// Top level of the run-length sprite line blitter: config registers, front, queue, back.
//
//  channel  | dir | modport | handshake     | payload
//  ---------+-----+---------+---------------+----------------------------------------------
//  i_in     | in  | sink    | valid / ready | cmd, stream_word, start_x, start_y, zoom
//  o_res    | out | source  | valid / ready | kind, address, pixel, end_of_shape, last
//  i_cfg    | in  | sink    | valid / ready | index, data (ready always high)
//
//  The front takes one request per cycle while the 4-entry command queue has room. The
//  back spends one cycle per pixel (up to 4 per 8-bit word) and one per line-finished
//  result, when the output is free; a line start or a skip uses the shared multiplier and
//  then the add. Ignored requests, and the pixel and skip words of a clipped line, cost
//  the back nothing. Reset is synchronous, active low; no clearing pass. A stalled result
//  holds in the output register while the front keeps filling the queue.
module rle_sprite_line_blitter
    import rslb_pkg::*;
#(
    parameter int ADDR_BITS  = 24,
    parameter int CHAR_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rslb_in_if.sink      i_in,
    rslb_out_if.source   o_res,
    rslb_cfg_if.sink     i_cfg
);

    t_cfg r_cfg;
    logic q_push, q_pop, q_full, q_valid;
    t_cmd q_entry, q_head;

    // Configuration writes are always taken; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_base   <= '0;
            r_cfg.row_bytes    <= ROW_BYTES_RST;
            r_cfg.screen_width <= SCREEN_WIDTH_RST;
            r_cfg.visible_rows <= VISIBLE_ROWS_RST;
            r_cfg.high_color   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FRAME_BASE:   r_cfg.frame_base   <= i_cfg.data;
                CFG_ROW_BYTES:    r_cfg.row_bytes    <= i_cfg.data[13:0];
                CFG_SCREEN_WIDTH: r_cfg.screen_width <= i_cfg.data[11:0];
                CFG_VISIBLE_ROWS: r_cfg.visible_rows <= i_cfg.data[11:0];
                CFG_HIGH_COLOR:   r_cfg.high_color   <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    // Front: classify each request against the line and run state
    rslb_front #(
        .CHAR_WIDTH (CHAR_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_entry (q_entry)
    );

    // Queue: decouple request intake from result delivery
    rslb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Back: step x, form addresses and drive the result register
    rslb_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_res        (o_res)
    );

endmodule

FILE: hdl/rslb_front.sv
// Front end: accept requests, track line and run state, classify into commands.
module rslb_front
    import rslb_pkg::*;
#(
    parameter int CHAR_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rslb_in_if.sink        i_in,
    input  t_cfg           i_cfg,
    input  logic           i_full,
    output logic           o_push,
    output t_cmd           o_entry
);

    localparam int CW_W   = $clog2(CHAR_WIDTH + 1);
    localparam int SPAN_W = 24 + CW_W - 16;

    logic        r_in_line, n_in_line;
    logic        r_draw_en, n_draw_en;
    logic [23:0] r_left, n_left;

    logic                 accept;
    logic [24+CW_W-1:0]   span_prod;
    logic [SPAN_W-1:0]    span;
    logic [16:0]          x_end;
    logic                 y_ok, x_ok;
    logic [2:0]           per, take;
    logic [7:0]           tok;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    // Clip test on the scaled span of one character cell
    assign span_prod = i_in.zoom * CW_W'(CHAR_WIDTH);
    assign span      = span_prod[24+CW_W-1:16];
    assign x_end     = 17'(i_in.start_x[30:16]) + 17'(span);
    assign y_ok      = !i_in.start_y[15] && (i_in.start_y[14:0] < {3'b000, i_cfg.visible_rows});
    assign x_ok      = !i_in.start_x[31] && (x_end < 17'(i_cfg.screen_width));

    assign per  = i_cfg.high_color ? 3'd2 : 3'd4;
    assign take = (r_left < 24'(per)) ? r_left[2:0] : per;
    assign tok  = i_in.stream_word[31:24];

    always_comb begin
        n_in_line     = r_in_line;
        n_draw_en     = r_draw_en;
        n_left        = r_left;
        o_push        = 1'b0;
        o_entry.op    = OP_PIXELS;
        o_entry.data  = (i_in.cmd == CMD_START) ? i_in.start_x : i_in.stream_word;
        o_entry.y     = i_in.start_y;
        o_entry.zoom  = i_in.zoom;
        o_entry.take  = take;
        o_entry.eos   = (tok == TOK_END);
        if (accept) begin
            if (i_in.cmd == CMD_START) begin
                // abandon any open line
                n_in_line  = 1'b1;
                n_draw_en  = y_ok && x_ok;
                n_left     = '0;
                o_entry.op = OP_START;
                o_push     = 1'b1;
            end else if (r_in_line) begin
                if (r_left != '0) begin
                    n_left     = r_left - 24'(take);
                    o_entry.op = OP_PIXELS;
                    o_push     = r_draw_en;
                end else begin
                    case (tok)
                        TOK_DRAW: begin
                            n_left = i_in.stream_word[23:0];
                        end
                        TOK_SKIP: begin
                            o_entry.op = OP_SKIP;
                            o_push     = r_draw_en;
                        end
                        TOK_END, TOK_LINE: begin
                            n_in_line  = 1'b0;
                            n_draw_en  = 1'b0;
                            o_entry.op = OP_FINISH;
                            o_push     = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_line <= 1'b0;
            r_draw_en <= 1'b0;
            r_left    <= '0;
        end else begin
            r_in_line <= n_in_line;
            r_draw_en <= n_draw_en;
            r_left    <= n_left;
        end
    end

endmodule

FILE: hdl/rslb_queue.sv
// Short command queue between front and back end.
module rslb_queue
    import rslb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_entry,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr == QPTR_W'(r_rd + r_count[QPTR_W-1:0])) else $error("queue pointers out of step");
`endif

endmodule

FILE: hdl/rslb_back.sv
// Back end: execute queued commands, step x and emit results through an output register.
module rslb_back
    import rslb_pkg::*;
#(
    parameter int ADDR_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_head_valid,
    input  t_cmd          i_head,
    output logic          o_pop,
    rslb_out_if.source    o_res
);

    t_back_state          r_state, n_state;
    logic [47:0]          r_x, n_x;
    logic [23:0]          r_zoom, n_zoom;
    logic [ADDR_BITS-1:0] r_line_off, n_line_off;
    logic [47:0]          r_mul, n_mul;
    logic [1:0]           r_idx, n_idx;
    logic                 r_out_valid, n_out_valid;
    logic                 r_kind, n_kind;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [15:0]          r_pixel, n_pixel;
    logic                 r_eos, n_eos;
    logic                 r_last, n_last;

    logic signed [24:0]   mul_a, mul_b;
    logic signed [49:0]   mul_p;
    logic                 can_emit, pix_done;
    logic [ADDR_BITS-1:0] x_part, pix_addr;
    logic [15:0]          pix_val;

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_kind;
    assign o_res.address      = r_addr;
    assign o_res.pixel        = r_pixel;
    assign o_res.end_of_shape = r_eos;
    assign o_res.last         = r_last;

    assign can_emit = !r_out_valid || o_res.ready;
    assign pix_done = ({1'b0, r_idx} + 3'd1) == i_head.take;

    // Shared multiplier: row offset on line start, count times zoom on skip
    assign mul_a = (i_head.op == OP_START) ? 25'($signed(i_head.y)) : {1'b0, i_head.data[23:0]};
    assign mul_b = (i_head.op == OP_START) ? {11'd0, i_cfg.row_bytes} : {1'b0, r_zoom};
    assign mul_p = mul_a * mul_b;

    assign x_part   = i_cfg.high_color ? ADDR_BITS'({r_x[30:16], 1'b0}) : r_x[16 +: ADDR_BITS];
    assign pix_addr = r_line_off + x_part;

    always_comb begin
        pix_val = '0;
        if (i_cfg.high_color) begin
            pix_val = r_idx[0] ? i_head.data[15:0] : i_head.data[31:16];
        end else begin
            case (r_idx)
                2'd0:    pix_val = {8'd0, i_head.data[31:24]};
                2'd1:    pix_val = {8'd0, i_head.data[23:16]};
                2'd2:    pix_val = {8'd0, i_head.data[15:8]};
                default: pix_val = {8'd0, i_head.data[7:0]};
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_zoom      = r_zoom;
        n_line_off  = r_line_off;
        n_mul       = r_mul;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_res.ready;
        n_kind      = r_kind;
        n_addr      = r_addr;
        n_pixel     = r_pixel;
        n_eos       = r_eos;
        n_last      = r_last;
        o_pop       = 1'b0;
        case (r_state)
            BK_RUN: begin
                if (i_head_valid) begin
                    case (i_head.op)
                        OP_START: begin
                            n_x     = {{16{i_head.data[31]}}, i_head.data};
                            n_zoom  = i_head.zoom;
                            n_mul   = mul_p[47:0];
                            o_pop   = 1'b1;
                            n_state = BK_OFFSET;
                        end
                        OP_SKIP: begin
                            n_mul   = mul_p[47:0];
                            o_pop   = 1'b1;
                            n_state = BK_SKIP;
                        end
                        OP_PIXELS: begin
                            if (can_emit) begin
                                n_out_valid = 1'b1;
                                n_kind      = KIND_PIXEL;
                                n_addr      = pix_addr;
                                n_pixel     = pix_val;
                                n_eos       = 1'b0;
                                n_last      = pix_done;
                                n_x         = r_x + 48'(r_zoom);
                                if (pix_done) begin
                                    n_idx = '0;
                                    o_pop = 1'b1;
                                end else begin
                                    n_idx = r_idx + 2'd1;
                                end
                            end
                        end
                        default: begin
                            // line finished
                            if (can_emit) begin
                                n_out_valid = 1'b1;
                                n_kind      = KIND_FINISH;
                                n_addr      = '0;
                                n_pixel     = '0;
                                n_eos       = i_head.eos;
                                n_last      = 1'b1;
                                o_pop       = 1'b1;
                            end
                        end
                    endcase
                end
            end
            BK_OFFSET: begin
                n_line_off = ADDR_BITS'(i_cfg.frame_base) + r_mul[ADDR_BITS-1:0];
                n_state    = BK_RUN;
            end
            BK_SKIP: begin
                n_x     = r_x + r_mul;
                n_state = BK_RUN;
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_x         <= '0;
            r_zoom      <= '0;
            r_line_off  <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_x         <= n_x;
            r_zoom      <= n_zoom;
            r_line_off  <= n_line_off;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul   <= n_mul;
        r_kind  <= n_kind;
        r_addr  <= n_addr;
        r_pixel <= n_pixel;
        r_eos   <= n_eos;
        r_last  <= n_last;
    end

`ifndef NO_ASSERTIONS
    a_one_cycle_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_RUN) |=> (r_state == BK_RUN)) else $error("offset or skip step stuck");
    a_idx_on_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> (i_head_valid && i_head.op == OP_PIXELS))
        else $error("pixel index set without a pixel word at the head");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_OFFSET || r_state == BK_SKIP) |-> !o_pop)
        else $error("pop during multi-cycle step");
`endif

endmodule
